// ===== sv/dxt_bd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_bd_pkg
// Shared types, constants and arithmetic helpers of the dxt block decoder.
// ----------------------------------------------------------------------------
package dxt_bd_pkg;

  // block format codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam int unsigned TexelsPerBlock = 16;
  localparam int unsigned CntW           = $clog2(TexelsPerBlock);

  typedef enum logic [1:0] {
    AM_DIRECT = 2'd0,
    AM_DIV5   = 2'd1,
    AM_DIV7   = 2'd2
  } alpha_mode_e;

  typedef logic [31:0][7:0] exp5_tbl_t;
  typedef logic [63:0][7:0] exp6_tbl_t;

  // c * 255 / (2^n - 1), floored, worked out at elaboration
  function automatic exp5_tbl_t build_exp5();
    exp5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'(i * 255 / 31);
    end
    return t;
  endfunction

  function automatic exp6_tbl_t build_exp6();
    exp6_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'(i * 255 / 63);
    end
    return t;
  endfunction

  localparam exp5_tbl_t Exp5 = build_exp5();
  localparam exp6_tbl_t Exp6 = build_exp6();

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // floor division by small constants through reciprocal multiplication
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd2341;
    return p[21:14];
  endfunction

endpackage

// ===== sv/dxt_block_decode_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_block_decode_unit
// Decodes one DXT1/DXT3/DXT5 4x4 block per beat into sixteen ABGR8888 texels.
// ----------------------------------------------------------------------------
// a block beat is held in the block register; its first texel then passes the s1, s2 and output registers to m_axis
// one texel per cycle while m_axis is not stalled; the next block
//   is taken while the last texel of the current one is issued, so no bubbles
// three register stages after the issue counter: endpoint expand, weighted
//   sums, constant division and palette select
// reset clears all valid bits, the texel counter and sets the format to DXT1
module dxt_block_decode_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i,     // block_format
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // color_part[63:0], alpha_part[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // texel_color[31:0], texel_row[33:32],
                                       // texel_column[35:34], zero[39:36]
  output logic         m_axis_tlast    // last_texel
);

  localparam int unsigned CntW = dxt_bd_pkg::CntW;
  localparam logic [CntW-1:0] CntLast = CntW'(dxt_bd_pkg::TexelsPerBlock - 1);

  typedef struct packed {
    dxt_bd_pkg::rgb_t c0;
    dxt_bd_pkg::rgb_t c1;
    logic [1:0]       sel;
    logic [1:0]       fmt;
    logic             three;
    logic [3:0]       nib;
    logic [2:0]       code;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [CntW-1:0]  idx;
  } s1_t;

  typedef struct packed {
    dxt_bd_pkg::rgb_t        c0;
    dxt_bd_pkg::rgb_t        c1;
    logic [2:0][8:0]         sum2;
    logic [2:0][9:0]         sum_a;
    logic [2:0][9:0]         sum_b;
    logic [1:0]              sel;
    logic                    three;
    dxt_bd_pkg::alpha_mode_e amode;
    logic [7:0]              adir;
    logic [10:0]             anum;
    logic [CntW-1:0]         idx;
  } s2_t;

  // configuration register
  logic [1:0] fmt_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dxt_bd_pkg::FMT_DXT1;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // pipeline advance: the whole pipe moves unless the output beat is stalled
  logic en;
  logic v1_q, v2_q, v3_q;
  assign en = !v3_q || m_axis_tready;

  // block holding register and texel counter
  logic            blk_valid_q;
  logic [63:0]     blk_color_q;
  logic [63:0]     blk_alpha_q;
  logic [1:0]      blk_fmt_q;
  logic [CntW-1:0] cnt_q;
  logic            issue;
  logic            s_acc;

  assign issue         = blk_valid_q && en;
  assign s_axis_tready = !blk_valid_q || (en && cnt_q == CntLast);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (s_acc) begin
        blk_valid_q <= 1'b1;
      end else if (issue && cnt_q == CntLast) begin
        blk_valid_q <= 1'b0;
      end
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      blk_color_q <= s_axis_tdata[63:0];
      blk_alpha_q <= s_axis_tdata[127:64];
      blk_fmt_q   <= fmt_q;
    end
  end

  // issue: endpoint expansion and per-texel field extraction
  s1_t         s1_d, s1_q;
  logic [15:0] e0, e1;

  always_comb begin
    e0        = blk_color_q[47:32];
    e1        = blk_color_q[63:48];
    s1_d.c0.r = dxt_bd_pkg::Exp5[e0[15:11]];
    s1_d.c0.g = dxt_bd_pkg::Exp6[e0[10:5]];
    s1_d.c0.b = dxt_bd_pkg::Exp5[e0[4:0]];
    s1_d.c1.r = dxt_bd_pkg::Exp5[e1[15:11]];
    s1_d.c1.g = dxt_bd_pkg::Exp6[e1[10:5]];
    s1_d.c1.b = dxt_bd_pkg::Exp5[e1[4:0]];
    s1_d.sel   = blk_color_q[{1'b0, cnt_q, 1'b0} +: 2];
    s1_d.fmt   = blk_fmt_q;
    s1_d.three = (blk_fmt_q == dxt_bd_pkg::FMT_DXT1) && (e0 <= e1);
    s1_d.nib   = blk_alpha_q[{cnt_q, 2'b00} +: 4];
    s1_d.code  = blk_alpha_q[6'(cnt_q) * 6'd3 +: 3];
    s1_d.a0    = blk_alpha_q[55:48];
    s1_d.a1    = blk_alpha_q[63:56];
    s1_d.idx   = cnt_q;
  end

  // stage 2: channel sums and alpha numerator
  s2_t        s2_d, s2_q;
  logic [2:0] w0, w1;

  always_comb begin
    s2_d.c0    = s1_q.c0;
    s2_d.c1    = s1_q.c1;
    s2_d.sel   = s1_q.sel;
    s2_d.three = s1_q.three;
    s2_d.idx   = s1_q.idx;
    s2_d.sum2[0]  = 9'(s1_q.c0.r) + 9'(s1_q.c1.r);
    s2_d.sum2[1]  = 9'(s1_q.c0.g) + 9'(s1_q.c1.g);
    s2_d.sum2[2]  = 9'(s1_q.c0.b) + 9'(s1_q.c1.b);
    s2_d.sum_a[0] = {1'b0, s1_q.c0.r, 1'b0} + 10'(s1_q.c1.r);
    s2_d.sum_a[1] = {1'b0, s1_q.c0.g, 1'b0} + 10'(s1_q.c1.g);
    s2_d.sum_a[2] = {1'b0, s1_q.c0.b, 1'b0} + 10'(s1_q.c1.b);
    s2_d.sum_b[0] = 10'(s1_q.c0.r) + {1'b0, s1_q.c1.r, 1'b0};
    s2_d.sum_b[1] = 10'(s1_q.c0.g) + {1'b0, s1_q.c1.g, 1'b0};
    s2_d.sum_b[2] = 10'(s1_q.c0.b) + {1'b0, s1_q.c1.b, 1'b0};

    w1 = s1_q.code - 3'd1;
    if (s1_q.a0 > s1_q.a1) begin
      w0 = 3'(4'd8 - {1'b0, s1_q.code});
    end else begin
      w0 = 3'd6 - s1_q.code;
    end
    s2_d.anum = 11'(w0) * 11'(s1_q.a0) + 11'(w1) * 11'(s1_q.a1);

    s2_d.amode = dxt_bd_pkg::AM_DIRECT;
    s2_d.adir  = 8'd255;
    priority if (s1_q.fmt == dxt_bd_pkg::FMT_DXT1) begin
      // transparent black for index 3 of a three-colour block
      s2_d.adir = (s1_q.three && s1_q.sel == 2'd3) ? 8'd0 : 8'd255;
    end else if (s1_q.fmt == dxt_bd_pkg::FMT_DXT3) begin
      s2_d.adir = {s1_q.nib, s1_q.nib};
    end else if (s1_q.code == 3'd0) begin
      s2_d.adir = s1_q.a0;
    end else if (s1_q.code == 3'd1) begin
      s2_d.adir = s1_q.a1;
    end else if (s1_q.a0 > s1_q.a1) begin
      s2_d.amode = dxt_bd_pkg::AM_DIV7;
    end else if (s1_q.code < 3'd6) begin
      s2_d.amode = dxt_bd_pkg::AM_DIV5;
    end else begin
      s2_d.adir = (s1_q.code == 3'd6) ? 8'd0 : 8'd255;
    end
  end

  // stage 3: constant division, palette select, output register
  logic [31:0]     color_d, color_q;
  logic [CntW-1:0] idx3_q;
  logic [7:0]      ch0 [3];
  logic [7:0]      ch1 [3];
  logic [7:0]      chv [3];
  logic [7:0]      alpha;

  always_comb begin
    ch0[0] = s2_q.c0.r;
    ch0[1] = s2_q.c0.g;
    ch0[2] = s2_q.c0.b;
    ch1[0] = s2_q.c1.r;
    ch1[1] = s2_q.c1.g;
    ch1[2] = s2_q.c1.b;
    for (int k = 0; k < 3; k++) begin
      unique case (s2_q.sel)
        2'd0:    chv[k] = ch0[k];
        2'd1:    chv[k] = ch1[k];
        2'd2:    chv[k] = s2_q.three ? s2_q.sum2[k][8:1]
                                     : dxt_bd_pkg::div3(s2_q.sum_a[k]);
        default: chv[k] = s2_q.three ? 8'd0 : dxt_bd_pkg::div3(s2_q.sum_b[k]);
      endcase
    end
    unique case (s2_q.amode)
      dxt_bd_pkg::AM_DIV5: alpha = dxt_bd_pkg::div5(s2_q.anum);
      dxt_bd_pkg::AM_DIV7: alpha = dxt_bd_pkg::div7(s2_q.anum);
      default:             alpha = s2_q.adir;
    endcase
    color_d = {alpha, chv[2], chv[1], chv[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      color_q <= color_d;
      idx3_q  <= s2_q.idx;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {4'd0, idx3_q[1:0], idx3_q[3:2], color_q};
  assign m_axis_tlast  = (idx3_q == CntLast);

  // a new block only enters when the previous one has issued its last texel
  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !blk_valid_q || cnt_q == CntLast)
    else $error("block accepted while texels still pending");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> blk_valid_q && cnt_q == '0)
    else $error("accepted block does not start at texel zero");

  a_stall_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && !s_acc |=> $stable(cnt_q) && $stable(blk_valid_q))
    else $error("texel counter moved during a stall");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[35:32] == 4'hF)
    else $error("last beat is not the bottom-right texel");

endmodule
